// ===== rtl/stepper_latch_sequencer_homing_macros.svh =====
// assertion macros for the stepper latch sequencer result register module
`ifndef STEPPER_LATCH_SEQUENCER_HOMING_MACROS_SVH
`define STEPPER_LATCH_SEQUENCER_HOMING_MACROS_SVH

// property that holds at every edge outside reset
`define SLSH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("slsh assertion failed");

// implication checked in the cycle after its trigger
`define SLSH_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("slsh next-cycle assertion failed");

`endif

// ===== rtl/slsh_pkg.sv =====
// types and constants for the stepper latch sequencer
package slsh_pkg;

   // width of the travel step counter
   localparam int COUNT_BITS = 16;

   // saturation point of the step counter: min(2^COUNT_BITS-1, 65535)
   localparam logic [63:0] COUNT_FULL = (64'd1 << COUNT_BITS) - 64'd1;
   localparam logic [15:0] COUNT_LIMIT =
      (COUNT_BITS >= 16) ? 16'hFFFF : COUNT_FULL[15:0];

   // command codes
   localparam logic [1:0] CMD_STEP  = 2'd0;
   localparam logic [1:0] CMD_CAL   = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;
   localparam logic [1:0] CMD_OFF   = 2'd3;

   // calibration phase codes
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_LEFT   = 2'd1;
   localparam logic [1:0] PH_RIGHT  = 2'd2;
   localparam logic [1:0] PH_CENTER = 2'd3;

   // limit status codes
   localparam logic [1:0] LIM_NONE  = 2'd0;
   localparam logic [1:0] LIM_LEFT  = 2'd1;
   localparam logic [1:0] LIM_RIGHT = 2'd2;

   // one input item
   typedef struct packed {
      logic [1:0] command;
      logic       motor;
      logic       dir;
      logic       left_edge;
      logic       right_edge;
      logic       left_level;
      logic       right_level;
   } item_type;

   // everything the emitter needs to play out the results of one item
   typedef struct packed {
      logic        write;     // four latch writes, else one result with no write
      logic        ccw;       // address order 3,2,1,0
      logic        motor;
      logic [1:0]  phase;
      logic [15:0] travel;
      logic [14:0] center;
      logic [1:0]  limit;
      logic        rejected;
   } burst_type;

endpackage

// ===== rtl/slsh_if.sv =====
// valid/ready channel interfaces for command items and result items
interface slsh_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic       motor;
   logic       dir;
   logic       left_edge;
   logic       right_edge;
   logic       left_level;
   logic       right_level;

   modport source (output valid, command, motor, dir, left_edge, right_edge,
                   left_level, right_level, input ready);
   modport sink   (input valid, command, motor, dir, left_edge, right_edge,
                   left_level, right_level, output ready);
endinterface

interface slsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  latch_addr;
   logic        latch_write;
   logic        last;
   logic [1:0]  phase;
   logic [15:0] travel_steps;
   logic [14:0] center_position;
   logic [1:0]  limit_status;
   logic        rejected;

   modport source (output valid, latch_addr, latch_write, last, phase, travel_steps,
                   center_position, limit_status, rejected, input ready);
   modport sink   (input valid, latch_addr, latch_write, last, phase, travel_steps,
                   center_position, limit_status, rejected, output ready);
endinterface

// ===== rtl/stepper_latch_sequencer_homing.sv =====
// top level of the two-stepper latch sequencer with homing calibration
//
//   channel  dir   handshake      payload
//   req      in    valid/ready    command, motor, dir, edges, levels
//   rsp      out   valid/ready    latch_addr, latch_write, last, status
//
// A step that is not rejected, a disable or an active-calibration tick gives four
// results, one per cycle while the receiver is ready; other items give one result.
// The result register is the limit: a new item is taken in the cycle the
// previous item's last result is taken, so no bubble between items.
// Calibration state updates when the item is accepted.
// Synchronous active-high reset clears the phase machine and the result register.
module stepper_latch_sequencer_homing (
   input  logic       clock,
   input  logic       reset,
   slsh_req_if.sink   req,
   slsh_rsp_if.source rsp
);
   import slsh_pkg::*;

   item_type  item;
   burst_type burst;
   logic      free;
   logic      accept;

   // pack the command item
   assign item.command     = req.command;
   assign item.motor       = req.motor;
   assign item.dir         = req.dir;
   assign item.left_edge   = req.left_edge;
   assign item.right_edge  = req.right_edge;
   assign item.left_level  = req.left_level;
   assign item.right_level = req.right_level;

   // accept when the result register is free or draining its last result
   assign req.ready = free;
   assign accept    = req.valid && free;

   slsh_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .burst  (burst)
   );

   slsh_emit u_emit (
      .clock (clock),
      .reset (reset),
      .load  (accept),
      .burst (burst),
      .free  (free),
      .rsp   (rsp)
   );

endmodule

// ===== rtl/slsh_ctrl.sv =====
// calibration phase machine and per-item burst decode
module slsh_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  slsh_pkg::item_type item,
   output slsh_pkg::burst_type burst
);
   import slsh_pkg::*;

   logic [1:0]  phase_ff,  phase_in;
   logic        motor_ff,  motor_in;
   logic [15:0] count_ff,  count_in;
   logic [14:0] remain_ff, remain_in;
   logic [15:0] travel_ff, travel_in;
   logic [14:0] center_ff, center_in;

   logic [15:0] count_inc;
   logic [14:0] remain_dec;
   logic [1:0]  limit;

   // saturating counter and centering countdown
   assign count_inc  = (count_ff < COUNT_LIMIT) ? count_ff + 16'd1 : count_ff;
   assign remain_dec = (remain_ff != 15'd0) ? remain_ff - 15'd1 : remain_ff;

   // limit status from sensor levels, left wins
   assign limit = item.left_level  ? LIM_LEFT :
                  item.right_level ? LIM_RIGHT : LIM_NONE;

   // next state and burst descriptor for the item
   always_comb begin
      phase_in  = phase_ff;
      motor_in  = motor_ff;
      count_in  = count_ff;
      remain_in = remain_ff;
      travel_in = travel_ff;
      center_in = center_ff;
      burst.write    = 1'b0;
      burst.ccw      = 1'b1;
      burst.motor    = item.motor;
      burst.rejected = 1'b0;
      case (item.command)
         CMD_STEP: begin
            if (phase_ff != PH_IDLE) begin
               burst.rejected = 1'b1;
            end else begin
               burst.write = 1'b1;
               burst.ccw   = item.dir;
            end
         end
         CMD_CAL: begin
            if (phase_ff != PH_IDLE) begin
               burst.rejected = 1'b1;
            end else begin
               motor_in = item.motor;
               count_in = 16'd0;
               phase_in = PH_LEFT;
            end
         end
         CMD_TICK: begin
            burst.motor = motor_ff;
            case (phase_ff)
               PH_LEFT: begin
                  burst.write = 1'b1;
                  if (item.left_edge) begin
                     phase_in = PH_RIGHT;
                     count_in = 16'd0;
                  end
               end
               PH_RIGHT: begin
                  burst.write = 1'b1;
                  burst.ccw   = 1'b0;
                  count_in    = count_inc;
                  if (item.right_edge) begin
                     travel_in = count_inc;
                     remain_in = count_inc[15:1];
                     if (count_inc[15:1] == 15'd0) begin
                        center_in = 15'd0;
                        phase_in  = PH_IDLE;
                     end else begin
                        phase_in  = PH_CENTER;
                     end
                  end
               end
               PH_CENTER: begin
                  burst.write = 1'b1;
                  remain_in   = remain_dec;
                  if (remain_dec == 15'd0) begin
                     center_in = travel_ff[15:1];
                     phase_in  = PH_IDLE;
                  end
               end
               default: begin
                  burst.write = 1'b0;
               end
            endcase
         end
         default: begin
            burst.write = 1'b1;
         end
      endcase
      burst.phase  = phase_in;
      burst.travel = travel_in;
      burst.center = center_in;
      burst.limit  = limit;
   end

   // calibration state, updated once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         motor_ff  <= 1'b0;
         count_ff  <= 16'd0;
         remain_ff <= 15'd0;
         travel_ff <= 16'd0;
         center_ff <= 15'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         motor_ff  <= motor_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         travel_ff <= travel_in;
         center_ff <= center_in;
      end
   end

endmodule

// ===== rtl/slsh_emit.sv =====
// result register that plays out one or four results per item
module slsh_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  slsh_pkg::burst_type burst,
   output logic                free,
   slsh_rsp_if.source          rsp
);
   import slsh_pkg::*;

   `include "stepper_latch_sequencer_homing_macros.svh"

   logic      busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   burst_type burst_ff;
   logic      last;
   logic      take;
   logic [1:0] low_addr;

   // last result: single result, or the fourth write
   assign last = !burst_ff.write || (idx_ff == 2'd3);
   assign take = busy_ff && rsp.ready;
   assign free = !busy_ff || (take && last);

   // address order within the step
   assign low_addr = burst_ff.ccw ? ~idx_ff : idx_ff;

   // result payload
   assign rsp.valid           = busy_ff;
   assign rsp.latch_addr      = burst_ff.write ? {burst_ff.motor, low_addr} : 3'd0;
   assign rsp.latch_write     = burst_ff.write;
   assign rsp.last            = last;
   assign rsp.phase           = burst_ff.phase;
   assign rsp.travel_steps    = burst_ff.travel;
   assign rsp.center_position = burst_ff.center;
   assign rsp.limit_status    = burst_ff.limit;
   assign rsp.rejected        = burst_ff.rejected;

   // burst sequencing
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (take) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // payload of the current item
   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff <= '0;
      end else if (load) begin
         burst_ff <= burst;
      end
   end

   // results with no latch write come alone and carry address zero
   `SLSH_ASSERT(a_single_last, clock, reset, !(busy_ff && !burst_ff.write) || last)
   `SLSH_ASSERT(a_addr_zero, clock, reset, burst_ff.write || (rsp.latch_addr == 3'd0))
   // a load only happens when the current item is finished
   `SLSH_ASSERT(a_load_free, clock, reset, !load || free)
   // a taken non-final write advances the index by one
   `SLSH_ASSERT_NEXT(a_idx_step, clock, reset, take && !last && !load,
      busy_ff && (idx_ff == $past(idx_ff) + 2'd1))

endmodule

// ===== sim/stepper_latch_sequencer_homing_tb.sv =====
// self-checking testbench for the two-stepper latch sequencer with homing calibration
module stepper_latch_sequencer_homing_tb;
   import slsh_pkg::*;

   localparam int RANDOM_ITEMS   = 240;
   localparam int STEADY_TICKS   = 16;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 16;
   localparam int CYCLE_LIMIT    = 2000000;

   // one result item as the sequencer should emit it
   typedef struct packed {
      logic [2:0]  addr;
      logic        write;
      logic        last;
      logic [1:0]  phase;
      logic [15:0] travel;
      logic [14:0] center;
      logic [1:0]  limit;
      logic        rejected;
   } latch_result_type;

   // directed stimulus row; first result typed in where it is obvious
   typedef struct {
      item_type         it;
      bit               pinned;
      latch_result_type first;
   } directed_row_type;

   logic clock;
   logic reset;

   slsh_req_if req_ch ();
   slsh_rsp_if rsp_ch ();

   stepper_latch_sequencer_homing DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // homing state mirrored by the predictor
   logic [1:0]  home_phase;
   logic        home_motor;
   logic [15:0] step_count;
   logic [14:0] center_left;
   logic [15:0] travel_len;
   logic [14:0] center_at;

   latch_result_type latch_burst_q[$];
   directed_row_type directed_rows[$];
   latch_result_type want;

   int  mismatches;
   int  items_sent;
   int  results_seen;
   int  refused_cmds;
   int  homings_done;
   int  cycles;
   int  hold;
   bit  steady;
   bit  squeeze_pending;

   // clock, period 20
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed", cycles,
                  latch_burst_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // bits = {motor, dir, left_edge, right_edge, left_level, right_level}
   function automatic item_type mk(logic [1:0] cmd, logic [5:0] bits);
      item_type it;
      it.command     = cmd;
      it.motor       = bits[5];
      it.dir         = bits[4];
      it.left_edge   = bits[3];
      it.right_edge  = bits[2];
      it.left_level  = bits[1];
      it.right_level = bits[0];
      return it;
   endfunction

   function automatic latch_result_type pin(logic [2:0] addr, logic wr, logic lst,
                                            logic [1:0] ph, logic [1:0] lim, logic rej);
      latch_result_type r;
      r.addr     = addr;
      r.write    = wr;
      r.last     = lst;
      r.phase    = ph;
      r.travel   = 16'd0;
      r.center   = 15'd0;
      r.limit    = lim;
      r.rejected = rej;
      return r;
   endfunction

   task automatic add_row(item_type it, bit pinned, latch_result_type first);
      directed_row_type row;
      row.it     = it;
      row.pinned = pinned;
      row.first  = first;
      directed_rows.push_back(row);
   endtask

   // predicts the latch writes and status of one command, returns result count
   function automatic int forecast_burst(item_type it);
      latch_result_type r;
      logic [1:0]       lim;
      logic [1:0]       k2;
      int               n;
      bit               wr;
      bit               ccw;
      bit               mot;
      bit               rej;
      lim = it.left_level ? LIM_LEFT : (it.right_level ? LIM_RIGHT : LIM_NONE);
      n   = 1;
      wr  = 1'b0;
      ccw = 1'b0;
      mot = 1'b0;
      rej = 1'b0;
      case (it.command)
         CMD_STEP: begin
            if (home_phase != PH_IDLE) begin
               rej = 1'b1;
            end else begin
               n   = 4;
               wr  = 1'b1;
               ccw = it.dir;
               mot = it.motor;
            end
         end
         CMD_CAL: begin
            if (home_phase != PH_IDLE) begin
               rej = 1'b1;
            end else begin
               home_motor = it.motor;
               step_count = 16'd0;
               home_phase = PH_LEFT;
            end
         end
         CMD_TICK: begin
            case (home_phase)
               PH_LEFT: begin
                  if (it.left_edge) begin
                     home_phase = PH_RIGHT;
                     step_count = 16'd0;
                  end
                  n   = 4;
                  wr  = 1'b1;
                  ccw = 1'b1;
                  mot = home_motor;
               end
               PH_RIGHT: begin
                  if (step_count < COUNT_LIMIT) step_count++;
                  if (it.right_edge) begin
                     travel_len  = step_count;
                     center_left = travel_len[15:1];
                     if (center_left == 15'd0) begin
                        center_at  = 15'd0;
                        home_phase = PH_IDLE;
                        homings_done++;
                     end else begin
                        home_phase = PH_CENTER;
                     end
                  end
                  n   = 4;
                  wr  = 1'b1;
                  mot = home_motor;
               end
               PH_CENTER: begin
                  if (center_left != 15'd0) center_left--;
                  if (center_left == 15'd0) begin
                     center_at  = travel_len[15:1];
                     home_phase = PH_IDLE;
                     homings_done++;
                  end
                  n   = 4;
                  wr  = 1'b1;
                  ccw = 1'b1;
                  mot = home_motor;
               end
               default: ;
            endcase
         end
         default: begin
            // coils off: always allowed, counterclockwise order
            n   = 4;
            wr  = 1'b1;
            ccw = 1'b1;
            mot = it.motor;
         end
      endcase
      if (rej) refused_cmds++;
      for (int k = 0; k < n; k++) begin
         k2         = k[1:0];
         r.addr     = wr ? {mot, (ccw ? ~k2 : k2)} : 3'd0;
         r.write    = wr;
         r.last     = (k == n - 1);
         r.phase    = home_phase;
         r.travel   = travel_len;
         r.center   = center_at;
         r.limit    = lim;
         r.rejected = rej;
         latch_burst_q.push_back(r);
      end
      return n;
   endfunction

   // idle length: mostly short, a few long
   function automatic int pick_stall();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 55) return 0;
      return pick_stall();
   endfunction

   // random command steered by the homing phase, so calibrations run to the end
   function automatic item_type pick_item();
      item_type    it;
      logic [31:0] rnd;
      int          r;
      rnd = $urandom;
      it  = rnd[7:0];
      r   = $urandom_range(0, 99);
      case (home_phase)
         PH_IDLE: begin
            if (r < 45) it.command = CMD_CAL;
         end
         PH_LEFT: begin
            if (r < 20) begin
               it.command   = CMD_TICK;
               it.left_edge = 1'b1;
            end else if (r < 85) begin
               it.command   = CMD_TICK;
               it.left_edge = 1'b0;
            end
         end
         PH_RIGHT: begin
            if (r < 15) begin
               it.command    = CMD_TICK;
               it.right_edge = 1'b1;
            end else if (r < 85) begin
               it.command    = CMD_TICK;
               it.right_edge = 1'b0;
            end
         end
         default: begin
            if (r < 85) it.command = CMD_TICK;
         end
      endcase
      return it;
   endfunction

   // offer one item, wait for it to be taken, then predict its results
   task automatic offer_item(input item_type it, input int gap, output int n);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= it.command;
      req_ch.motor       <= it.motor;
      req_ch.dir         <= it.dir;
      req_ch.left_edge   <= it.left_edge;
      req_ch.right_edge  <= it.right_edge;
      req_ch.left_level  <= it.left_level;
      req_ch.right_level <= it.right_level;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      n = forecast_burst(it);
   endtask

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] exp_val);
      mismatches++;
      $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what,
               got, exp_val);
   endtask

   // result receiver: random stalls, quiet stretches, one long hold-off
   initial begin
      rsp_ch.ready <= 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (squeeze_pending) begin
            squeeze_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end else if (steady) begin
            rsp_ch.ready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (((cycles / 400) % 5) == 0 || $urandom_range(0, 99) >= 15) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            hold = pick_stall() - 1;
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   // compare each taken result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (latch_burst_q.size() == 0) begin
            report_mismatch("result with nothing owed", 16'd1, 16'd0);
         end else begin
            want = latch_burst_q.pop_front();
            if (rsp_ch.latch_addr !== want.addr)
               report_mismatch("latch_addr", 16'(rsp_ch.latch_addr), 16'(want.addr));
            if (rsp_ch.latch_write !== want.write)
               report_mismatch("latch_write", 16'(rsp_ch.latch_write), 16'(want.write));
            if (rsp_ch.last !== want.last)
               report_mismatch("last", 16'(rsp_ch.last), 16'(want.last));
            if (rsp_ch.phase !== want.phase)
               report_mismatch("phase", 16'(rsp_ch.phase), 16'(want.phase));
            if (rsp_ch.travel_steps !== want.travel)
               report_mismatch("travel_steps", rsp_ch.travel_steps, want.travel);
            if (rsp_ch.center_position !== want.center)
               report_mismatch("center_position", 16'(rsp_ch.center_position),
                               16'(want.center));
            if (rsp_ch.limit_status !== want.limit)
               report_mismatch("limit_status", 16'(rsp_ch.limit_status), 16'(want.limit));
            if (rsp_ch.rejected !== want.rejected)
               report_mismatch("rejected", 16'(rsp_ch.rejected), 16'(want.rejected));
         end
         results_seen++;
      end
   end

   // stimulus
   initial begin
      int          n;
      int          gap;
      logic [31:0] rnd;
      req_ch.valid       <= 1'b0;
      req_ch.command     <= CMD_STEP;
      req_ch.motor       <= 1'b0;
      req_ch.dir         <= 1'b0;
      req_ch.left_edge   <= 1'b0;
      req_ch.right_edge  <= 1'b0;
      req_ch.left_level  <= 1'b0;
      req_ch.right_level <= 1'b0;
      reset              <= 1'b1;
      home_phase  = PH_IDLE;
      home_motor  = 1'b0;
      step_count  = 16'd0;
      center_left = 15'd0;
      travel_len  = 16'd0;
      center_at   = 15'd0;
      steady          = 1'b0;
      squeeze_pending = 1'b0;

      // plain steps and coils off straight after reset
      add_row(mk(CMD_STEP, 6'b0_0_0_0_0_0), 1'b1,
              pin(3'd0, 1'b1, 1'b0, PH_IDLE, LIM_NONE, 1'b0));
      add_row(mk(CMD_STEP, 6'b1_1_0_0_1_1), 1'b1,
              pin(3'd7, 1'b1, 1'b0, PH_IDLE, LIM_LEFT, 1'b0));
      add_row(mk(CMD_OFF, 6'b1_0_0_0_0_1), 1'b1,
              pin(3'd7, 1'b1, 1'b0, PH_IDLE, LIM_RIGHT, 1'b0));
      // tick while idle gives a lone status result
      add_row(mk(CMD_TICK, 6'b1_1_1_1_0_0), 1'b1,
              pin(3'd0, 1'b0, 1'b1, PH_IDLE, LIM_NONE, 1'b0));
      // start homing on the horizontal motor, then refused step and start
      add_row(mk(CMD_CAL, 6'b1_0_0_0_0_0), 1'b1,
              pin(3'd0, 1'b0, 1'b1, PH_LEFT, LIM_NONE, 1'b0));
      add_row(mk(CMD_STEP, 6'b0_0_0_0_1_0), 1'b1,
              pin(3'd0, 1'b0, 1'b1, PH_LEFT, LIM_LEFT, 1'b1));
      add_row(mk(CMD_CAL, 6'b0_1_0_0_0_1), 1'b1,
              pin(3'd0, 1'b0, 1'b1, PH_LEFT, LIM_RIGHT, 1'b1));
      // right edge ignored while seeking left, coils off allowed mid-homing
      add_row(mk(CMD_TICK, 6'b0_0_0_1_0_0), 1'b0, '0);
      add_row(mk(CMD_OFF, 6'b0_1_0_0_0_0), 1'b0, '0);
      add_row(mk(CMD_TICK, 6'b0_0_1_0_1_0), 1'b0, '0);
      // counting toward the right stop, stray left edge ignored
      add_row(mk(CMD_TICK, 6'b0_1_1_0_0_0), 1'b0, '0);
      add_row(mk(CMD_TICK, 6'b1_0_0_0_0_0), 1'b0, '0);
      add_row(mk(CMD_TICK, 6'b0_0_0_0_1_1), 1'b0, '0);
      add_row(mk(CMD_TICK, 6'b0_1_0_0_0_0), 1'b0, '0);
      add_row(mk(CMD_TICK, 6'b0_0_0_1_0_1), 1'b0, '0);
      // centering on an odd travel
      add_row(mk(CMD_STEP, 6'b1_1_0_0_0_0), 1'b0, '0);
      add_row(mk(CMD_TICK, 6'b0_0_1_1_0_0), 1'b0, '0);
      add_row(mk(CMD_TICK, 6'b0_0_0_0_0_0), 1'b0, '0);
      // travel of one step ends homing at once with center zero
      add_row(mk(CMD_CAL, 6'b0_0_0_0_0_0), 1'b0, '0);
      add_row(mk(CMD_TICK, 6'b1_0_1_0_0_0), 1'b0, '0);
      add_row(mk(CMD_TICK, 6'b0_0_0_1_0_1), 1'b0, '0);
      // travel of two leaves one centering step pending
      add_row(mk(CMD_CAL, 6'b1_1_0_0_0_0), 1'b0, '0);
      add_row(mk(CMD_TICK, 6'b0_0_1_0_1_0), 1'b0, '0);
      add_row(mk(CMD_TICK, 6'b0_0_0_0_0_0), 1'b0, '0);
      add_row(mk(CMD_TICK, 6'b0_0_0_1_0_0), 1'b0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (directed_rows[j]) begin
         offer_item(directed_rows[j].it, (j % 3 == 2) ? pick_stall() : 0, n);
         if (directed_rows[j].pinned)
            latch_burst_q[latch_burst_q.size() - n] = directed_rows[j].first;
      end

      // random part, with one long receiver hold-off
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) squeeze_pending = 1'b1;
         gap = (i % 64 < 16) ? 0 : pick_gap();
         offer_item(pick_item(), gap, n);
      end

      // close any homing still running
      while (home_phase != PH_IDLE)
         offer_item(mk(CMD_TICK, 6'b0_0_1_1_0_0), pick_gap(), n);

      // full-speed homing with the receiver always ready
      steady = 1'b1;
      offer_item(mk(CMD_CAL, 6'b1_0_0_0_0_0), 0, n);
      offer_item(mk(CMD_TICK, 6'b0_1_1_0_1_0), 0, n);
      repeat (STEADY_TICKS) begin
         rnd = $urandom;
         offer_item(mk(CMD_TICK, {rnd[0], rnd[1], rnd[2], 1'b0, rnd[3], rnd[4]}), 0, n);
      end
      offer_item(mk(CMD_TICK, 6'b0_0_0_1_0_1), 0, n);
      while (home_phase != PH_IDLE) begin
         rnd = $urandom;
         offer_item(mk(CMD_TICK, rnd[5:0]), 0, n);
      end
      steady = 1'b0;
      req_ch.valid <= 1'b0;

      // drain
      while (latch_burst_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands and %0d results, %0d refused while homing",
               items_sent, results_seen, refused_cmds);
      $display("%0d homing runs finished, last travel %0d steps, center %0d",
               homings_done, travel_len, center_at);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
